>>> rtl/core/pfb_pkg.sv
// shared types, codes and reset values for the flood block list
// no dependencies
package pfb_pkg;

    localparam int LIST_DEPTH_DEF = 16;
    localparam int CFG_IW         = 8;
    localparam int CFG_DW         = 32;
    localparam int EW             = 5;

    localparam logic [CFG_IW-1:0] REG_RESET_GAP  = 8'd0;
    localparam logic [CFG_IW-1:0] REG_FAST_DELTA = 8'd1;
    localparam logic [CFG_IW-1:0] REG_FAST_WAIT  = 8'd2;
    localparam logic [CFG_IW-1:0] REG_FLOOD_CNT  = 8'd3;
    localparam logic [CFG_IW-1:0] REG_BLOCK_SEC  = 8'd4;

    localparam logic [23:0] RST_RESET_GAP  = 24'd5000000;
    localparam logic [15:0] RST_FAST_DELTA = 16'd500;
    localparam logic [15:0] RST_FAST_WAIT  = 16'd900;
    localparam logic [15:0] RST_FLOOD_CNT  = 16'd500;
    localparam logic [15:0] RST_BLOCK_SEC  = 16'd20;

    typedef enum logic {
        OP_PACKET = 1'b0,
        OP_TICK   = 1'b1
    } t_opcode;

    typedef enum logic [1:0] {
        EV_NONE      = 2'd0,
        EV_BLOCKED   = 2'd1,
        EV_UNBLOCKED = 2'd2,
        EV_DROPPED   = 2'd3
    } t_event;

    typedef enum logic [1:0] {
        S_IDLE,
        S_SCAN,
        S_EXPIRE,
        S_SHIFT
    } t_state;

    typedef struct packed {
        t_opcode     opcode;
        logic [31:0] source_address;
        logic [23:0] wait_us;
    } t_item;

    typedef struct packed {
        t_event        event_res;
        logic [31:0]   event_address;
        logic          listed;
        logic [15:0]   burst_count;
        logic [EW-1:0] entries_used;
    } t_result;

    typedef struct packed {
        logic [23:0] reset_gap_us;
        logic [15:0] fast_delta_us;
        logic [15:0] fast_wait_us;
        logic [15:0] flood_count;
        logic [15:0] block_seconds;
    } t_cfg;

    typedef struct packed {
        logic [31:0] address;
        logic [31:0] stamp;
    } t_entry;

endpackage

>>> rtl/core/pfb_ram.sv
// generic single write, single read port ram with registered read
// no dependencies
module pfb_ram #(
    parameter int WIDTH = 64,
    parameter int DEPTH = 16
) (
    input  logic                                  i_clk,
    input  logic                                  i_wr_en,
    input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] i_wr_addr,
    input  logic [WIDTH-1:0]                      i_wr_data,
    input  logic                                  i_rd_en,
    input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] i_rd_addr,
    output logic [WIDTH-1:0]                      o_rd_data
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rd_data;

    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
        if (i_rd_en) begin
            r_rd_data <= r_mem[i_rd_addr];
        end
    end

    assign o_rd_data = r_rd_data;

endmodule

>>> rtl/core/pfb_cfg.sv
// configuration register file, always ready
// depends on pfb_pkg
module pfb_cfg (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_cfg_valid,
    output logic                        o_cfg_ready,
    input  logic [pfb_pkg::CFG_IW-1:0]  i_cfg_index,
    input  logic [pfb_pkg::CFG_DW-1:0]  i_cfg_data,
    output pfb_pkg::t_cfg               o_cfg
);
    import pfb_pkg::*;

    t_cfg r_cfg;
    t_cfg n_cfg;

    always_comb begin
        n_cfg = r_cfg;
        if (i_cfg_valid) begin
            case (i_cfg_index)
                REG_RESET_GAP:  n_cfg.reset_gap_us  = i_cfg_data[23:0];
                REG_FAST_DELTA: n_cfg.fast_delta_us = i_cfg_data[15:0];
                REG_FAST_WAIT:  n_cfg.fast_wait_us  = i_cfg_data[15:0];
                REG_FLOOD_CNT:  n_cfg.flood_count   = i_cfg_data[15:0];
                REG_BLOCK_SEC:  n_cfg.block_seconds = i_cfg_data[15:0];
                default: n_cfg = r_cfg;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.reset_gap_us  <= RST_RESET_GAP;
            r_cfg.fast_delta_us <= RST_FAST_DELTA;
            r_cfg.fast_wait_us  <= RST_FAST_WAIT;
            r_cfg.flood_count   <= RST_FLOOD_CNT;
            r_cfg.block_seconds <= RST_BLOCK_SEC;
        end else begin
            r_cfg <= n_cfg;
        end
    end

    assign o_cfg_ready = 1'b1;
    assign o_cfg       = r_cfg;

endmodule

>>> rtl/core/pfb_burst.sv
// burst counter and previous wait, updated on packet words
// depends on pfb_pkg
module pfb_burst (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  pfb_pkg::t_cfg i_cfg,
    input  logic          i_load,
    input  logic [23:0]   i_wait,
    input  logic          i_commit,
    input  logic          i_listed,
    output logic [15:0]   o_burst,
    output logic [15:0]   o_count
);
    import pfb_pkg::*;

    logic [23:0] r_prev;
    logic [15:0] r_cnt;
    logic [15:0] r_pre;
    logic [15:0] w_base;
    logic        w_grow_ok;
    logic        w_fast;

    assign w_base    = (i_wait > i_cfg.reset_gap_us) ? 16'd0 : r_cnt;
    assign w_grow_ok = {1'b0, i_wait} < ({1'b0, r_prev} + 25'(i_cfg.fast_delta_us));
    assign w_fast    = w_grow_ok && (i_wait <= 24'(i_cfg.fast_wait_us))
                       && (r_prev <= 24'(i_cfg.fast_wait_us)) && (w_base != 16'hFFFF);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_prev <= '0;
            r_cnt  <= '0;
        end else begin
            if (i_load) begin
                r_prev <= i_wait;
            end
            if (i_commit) begin
                r_cnt <= o_burst;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_load) begin
            r_pre <= w_fast ? w_base + 16'd1 : w_base;
        end
    end

    assign o_burst = i_listed ? 16'd0 : r_pre;
    assign o_count = r_cnt;

endmodule

>>> rtl/core/ping_flood_blocklist.sv
// echo-request flood detector with timed block list, top level
// depends on pfb_pkg, pfb_ram, pfb_cfg, pfb_burst
//
//  channel  | handshake               | payload
//  ---------+-------------------------+------------------------------
//  item     | i_start, o_busy         | i_item   (pfb_pkg::t_item)
//  result   | o_done (one-cycle)      | o_result (pfb_pkg::t_result)
//  config   | i_cfg_valid, o_cfg_ready| i_cfg_index, i_cfg_data
//
// the list sits in one ram read at one entry a cycle
// packet: search of every list entry, then the registered result
// tick: search up to the first expired entry, then its removal by compaction
// reset needs no clearing pass, list entries are only read below the count
// results cannot be stalled, config always ready
module ping_flood_blocklist #(
    parameter int LIST_DEPTH = pfb_pkg::LIST_DEPTH_DEF
) (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       i_start,
    output logic                       o_busy,
    input  pfb_pkg::t_item             i_item,
    output logic                       o_done,
    output pfb_pkg::t_result           o_result,
    input  logic                       i_cfg_valid,
    output logic                       o_cfg_ready,
    input  logic [pfb_pkg::CFG_IW-1:0] i_cfg_index,
    input  logic [pfb_pkg::CFG_DW-1:0] i_cfg_data
);
    import pfb_pkg::*;

    localparam int AW = (LIST_DEPTH > 1) ? $clog2(LIST_DEPTH) : 1;
    localparam int CW = $clog2(LIST_DEPTH + 1);
    localparam int DW = $bits(t_entry);

    t_cfg    w_cfg;
    t_state  r_state, n_state;
    t_item   r_item, n_item;
    t_result r_out, n_out;
    logic    r_done, n_done;
    logic    r_hit, n_hit;
    logic    r_pend, n_pend;
    logic [CW-1:0] r_count, n_count;
    logic [CW-1:0] r_idx, n_idx;
    logic [AW-1:0] r_cmp, n_cmp;
    logic [31:0]   r_sec, n_sec;
    logic [31:0]   r_ev_addr, n_ev_addr;

    logic          w_accept;
    logic          w_can_issue;
    logic          w_hit_now;
    logic          w_expired;
    t_entry        w_rd;
    logic [DW-1:0] w_rd_data;
    logic          w_rd_en, w_wr_en;
    logic [AW-1:0] w_rd_addr, w_wr_addr;
    t_entry        w_wr;
    logic          w_load, w_commit;
    logic [15:0]   w_burst, w_count;
    logic [CW-1:0] w_cnt_inc;

    pfb_cfg u_cfg (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_valid (i_cfg_valid),
        .o_cfg_ready (o_cfg_ready),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .o_cfg       (w_cfg)
    );

    pfb_burst u_burst (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_cfg    (w_cfg),
        .i_load   (w_load),
        .i_wait   (i_item.wait_us),
        .i_commit (w_commit),
        .i_listed (r_hit),
        .o_burst  (w_burst),
        .o_count  (w_count)
    );

    pfb_ram #(
        .WIDTH (DW),
        .DEPTH (LIST_DEPTH)
    ) u_list (
        .i_clk     (i_clk),
        .i_wr_en   (w_wr_en),
        .i_wr_addr (w_wr_addr),
        .i_wr_data (w_wr),
        .i_rd_en   (w_rd_en),
        .i_rd_addr (w_rd_addr),
        .o_rd_data (w_rd_data)
    );

    assign w_rd        = w_rd_data;
    assign o_busy      = (r_state != S_IDLE);
    assign w_accept    = i_start && !o_busy;
    assign w_can_issue = r_idx < r_count;
    assign w_hit_now   = r_pend && (w_rd.address == r_item.source_address);
    assign w_expired   = r_pend && ((r_sec - w_rd.stamp) >= 32'(w_cfg.block_seconds));
    assign w_cnt_inc   = r_idx + CW'(1);

    // next state
    always_comb begin
        n_state = r_state;
        case (r_state)
            S_IDLE: begin
                if (w_accept) begin
                    n_state = (i_item.opcode == OP_TICK) ? S_EXPIRE : S_SCAN;
                end
            end
            S_SCAN: begin
                if (!r_pend) begin
                    n_state = S_IDLE;
                end
            end
            S_EXPIRE: begin
                if (w_expired) begin
                    n_state = S_SHIFT;
                end else if (!r_pend) begin
                    n_state = S_IDLE;
                end
            end
            S_SHIFT: begin
                if (!r_pend && !w_can_issue) begin
                    n_state = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    // datapath and list access
    always_comb begin
        n_item    = r_item;
        n_out     = r_out;
        n_done    = 1'b0;
        n_hit     = r_hit;
        n_pend    = r_pend;
        n_count   = r_count;
        n_idx     = r_idx;
        n_cmp     = r_cmp;
        n_sec     = r_sec;
        n_ev_addr = r_ev_addr;
        w_rd_en   = 1'b0;
        w_rd_addr = r_idx[AW-1:0];
        w_wr_en   = 1'b0;
        w_wr_addr = r_count[AW-1:0];
        w_wr      = w_rd;
        w_load    = 1'b0;
        w_commit  = 1'b0;
        case (r_state)
            S_IDLE: begin
                if (w_accept) begin
                    n_item    = i_item;
                    n_hit     = 1'b0;
                    n_idx     = CW'(1);
                    n_cmp     = '0;
                    n_pend    = (r_count != '0);
                    w_rd_en   = (r_count != '0);
                    w_rd_addr = '0;
                    if (i_item.opcode == OP_TICK) begin
                        n_sec = r_sec + 32'd1;
                    end else begin
                        w_load = 1'b1;
                    end
                end
            end
            S_SCAN: begin
                if (r_pend) begin
                    if (w_hit_now) begin
                        n_hit = 1'b1;
                    end
                    if (w_can_issue) begin
                        w_rd_en = 1'b1;
                        n_cmp   = r_idx[AW-1:0];
                        n_idx   = w_cnt_inc;
                    end else begin
                        n_pend = 1'b0;
                    end
                end else begin
                    w_commit            = 1'b1;
                    n_done              = 1'b1;
                    n_out.event_res     = EV_NONE;
                    n_out.event_address = '0;
                    n_out.listed        = r_hit;
                    n_out.burst_count   = w_burst;
                    if (w_cfg.flood_count != '0 && w_burst == w_cfg.flood_count) begin
                        if (r_count < CW'(LIST_DEPTH)) begin
                            w_wr_en             = 1'b1;
                            w_wr.address        = r_item.source_address;
                            w_wr.stamp          = r_sec;
                            n_count             = r_count + CW'(1);
                            n_out.event_res     = EV_BLOCKED;
                            n_out.event_address = r_item.source_address;
                        end else begin
                            n_out.event_res = EV_DROPPED;
                        end
                    end
                    n_out.entries_used = EW'(n_count);
                end
            end
            S_EXPIRE: begin
                if (w_expired) begin
                    n_ev_addr = w_rd.address;
                    n_idx     = CW'(r_cmp) + CW'(1);
                    n_pend    = 1'b0;
                end else if (r_pend) begin
                    if (w_can_issue) begin
                        w_rd_en = 1'b1;
                        n_cmp   = r_idx[AW-1:0];
                        n_idx   = w_cnt_inc;
                    end else begin
                        n_pend = 1'b0;
                    end
                end else begin
                    n_done              = 1'b1;
                    n_out.event_res     = EV_NONE;
                    n_out.event_address = '0;
                    n_out.listed        = 1'b0;
                    n_out.burst_count   = w_count;
                    n_out.entries_used  = EW'(r_count);
                end
            end
            S_SHIFT: begin
                if (r_pend) begin
                    w_wr_en   = 1'b1;
                    w_wr_addr = r_cmp - AW'(1);
                end
                if (w_can_issue) begin
                    w_rd_en = 1'b1;
                    n_cmp   = r_idx[AW-1:0];
                    n_idx   = w_cnt_inc;
                    n_pend  = 1'b1;
                end else begin
                    n_pend = 1'b0;
                    if (!r_pend) begin
                        n_count             = r_count - CW'(1);
                        n_done              = 1'b1;
                        n_out.event_res     = EV_UNBLOCKED;
                        n_out.event_address = r_ev_addr;
                        n_out.listed        = 1'b0;
                        n_out.burst_count   = w_count;
                        n_out.entries_used  = EW'(n_count);
                    end
                end
            end
            default: n_done = 1'b0;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_done  <= 1'b0;
            r_pend  <= 1'b0;
            r_count <= '0;
            r_sec   <= '0;
        end else begin
            r_state <= n_state;
            r_done  <= n_done;
            r_pend  <= n_pend;
            r_count <= n_count;
            r_sec   <= n_sec;
        end
    end

    always_ff @(posedge i_clk) begin
        r_item    <= n_item;
        r_out     <= n_out;
        r_hit     <= n_hit;
        r_idx     <= n_idx;
        r_cmp     <= n_cmp;
        r_ev_addr <= n_ev_addr;
    end

    assign o_done   = r_done;
    assign o_result = r_out;

endmodule
